@@ sv/drti_pkg.sv @@
// ----------------------------------------------------------------------------
// drti_pkg
// Shared types, widths and the divide-by-ten digit table for the decimal
// round-to-integer pipeline.
// ----------------------------------------------------------------------------
package drti_pkg;

  // Field widths
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned LowWidth   = 64;
  localparam int unsigned HighWidth  = 32;
  localparam int unsigned MagWidth   = LowWidth + HighWidth;
  localparam int unsigned ScaleWidth = 5;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InBits     = OpWidth + MagWidth + ScaleWidth + 1;
  localparam int unsigned InDataW    = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits    = MagWidth + 1;
  localparam int unsigned OutDataW   = ((OutBits + 7) / 8) * 8;

  // Division layout: each divide-by-ten walks three 32-bit limbs,
  // one limb per pipeline stage, eight nibbles per limb
  localparam int unsigned LimbWidth     = 32;
  localparam int unsigned LimbsPerDiv   = MagWidth / LimbWidth;
  localparam int unsigned NibblesPerLimb = LimbWidth / 4;
  localparam int unsigned MaxScaleSteps = (2 ** ScaleWidth) - 1;
  localparam int unsigned NumDivStages  = MaxScaleSteps * LimbsPerDiv;

  // Digit table: index {remainder, nibble} < 160, entry {quotient, remainder}
  localparam int unsigned DivTabSize = 160;

  typedef enum logic [OpWidth-1:0] {
    OP_TRUNC = 2'd0,
    OP_FLOOR = 2'd1,
    OP_ROUND = 2'd2
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [MagWidth-1:0]   mag;
    logic [3:0]            rem;
    logic [3:0]            last;
    logic                  sticky;
    logic [ScaleWidth-1:0] scale;
    logic                  neg;
  } pipe_t;

  typedef logic [DivTabSize-1:0][7:0] div10_tab_t;

  // Build the table by counting, so no division is needed
  function automatic div10_tab_t build_div10_tab();
    div10_tab_t tab;
    logic [3:0] q;
    logic [3:0] r;
    q = '0;
    r = '0;
    for (int i = 0; i < DivTabSize; i++) begin
      tab[i] = {q, r};
      if (r == 4'd9) begin
        r = '0;
        q = q + 4'd1;
      end else begin
        r = r + 4'd1;
      end
    end
    return tab;
  endfunction

  localparam div10_tab_t DIV10_TAB = build_div10_tab();

  // Divide {rem_in, limb} by ten one nibble at a time; returns {quotient, rem}
  function automatic logic [LimbWidth+3:0] div10_limb(input logic [3:0] rem_in,
                                                      input logic [LimbWidth-1:0] limb);
    logic [3:0]           r;
    logic [LimbWidth-1:0] q;
    logic [7:0]           e;
    r = rem_in;
    q = '0;
    for (int n = NibblesPerLimb - 1; n >= 0; n--) begin
      e = DIV10_TAB[{r, limb[4*n +: 4]}];
      q[4*n +: 4] = e[7:4];
      r = e[3:0];
    end
    return {q, r};
  endfunction

endpackage

@@ sv/decimal_round_to_integer_core.sv @@
// ----------------------------------------------------------------------------
// decimal_round_to_integer_core
// Reduces a signed 96-bit decimal to an integer by truncate, floor or
// round-half-to-even, in a fully pipelined divide-by-ten chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis: operation, 96-bit magnitude, decimal scale
//   and sign. Each beat yields exactly one output beat on m_axis carrying the
//   integer magnitude (scale zero) and the unchanged sign.
//   Every beat passes through 93 divider stages (31 possible divide-by-ten
//   steps, three 32-bit limbs each, one limb per stage) plus one rounding and
//   output register on its way from accept to m_axis_tvalid.
//   Stages past the beat's own scale pass the value through untouched.
//   Throughput is one beat per cycle while the output is not stalled; the limb
//   divider in each stage, a chain of eight nibble table lookups, sets the clock.
//   When the receiver holds m_axis_tready low with a beat waiting, the whole
//   pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all stage valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module decimal_round_to_integer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] operation, [65:2] magnitude_low, [97:66] magnitude_high,
  // [102:98] decimal_scale, [103] negative
  input  logic [drti_pkg::InDataW-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [63:0] result_low, [95:64] result_high, [96] result_negative, rest zero
  output logic [drti_pkg::OutDataW-1:0] m_axis_tdata
);
  import drti_pkg::*;

  localparam int unsigned LastStage = NumDivStages - 1;

  logic                    adv;
  pipe_t                   in_beat;
  pipe_t                   src       [NumDivStages];
  pipe_t                   stage_d   [NumDivStages];
  pipe_t                   stage_q   [NumDivStages];
  logic [NumDivStages-1:0] vld_q;
  logic                    up;
  logic [MagWidth-1:0]     out_mag_d;
  logic [MagWidth-1:0]     out_mag_q;
  logic                    out_neg_q;
  logic                    out_vld_q;

  // Advance everything whenever the output slot is free or being taken
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack the input beat
  always_comb begin
    in_beat        = '0;
    in_beat.op     = op_e'(s_axis_tdata[OpWidth-1:0]);
    in_beat.mag    = s_axis_tdata[OpWidth +: MagWidth];
    in_beat.scale  = s_axis_tdata[OpWidth+MagWidth +: ScaleWidth];
    in_beat.neg    = s_axis_tdata[OpWidth+MagWidth+ScaleWidth];
  end

  // Divider stages: stage k handles one limb of divide step k/3
  for (genvar k = 0; k < NumDivStages; k++) begin : g_div
    localparam int unsigned DivIdx = k / LimbsPerDiv;
    localparam int unsigned Part   = k % LimbsPerDiv;
    localparam int unsigned LimbLo = LimbWidth * (LimbsPerDiv - 1 - Part);

    if (k == 0) begin : g_first
      assign src[k] = in_beat;
    end else begin : g_next
      assign src[k] = stage_q[k-1];
    end

    logic [LimbWidth+3:0] dv;
    logic [3:0]           rem_in;

    // Start each divide with a zero remainder, carry it between limbs
    assign rem_in = (Part == 0) ? 4'd0 : src[k].rem;
    assign dv     = div10_limb(rem_in, src[k].mag[LimbLo +: LimbWidth]);

    always_comb begin
      stage_d[k] = src[k];
      if (ScaleWidth'(DivIdx) < src[k].scale) begin
        if (Part == 0) begin
          stage_d[k].sticky = src[k].sticky || (src[k].last != 4'd0);
        end
        stage_d[k].mag[LimbLo +: LimbWidth] = dv[LimbWidth+3:4];
        stage_d[k].rem = dv[3:0];
        if (Part == LimbsPerDiv - 1) begin
          stage_d[k].last = dv[3:0];
        end
      end
    end

    // Hold the stage on stall, otherwise shift the beat on
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Decide the final increment from the discarded digits
  always_comb begin
    case (stage_q[LastStage].op)
      OP_FLOOR: up = stage_q[LastStage].neg &&
                     (stage_q[LastStage].sticky || (stage_q[LastStage].last != 4'd0));
      OP_ROUND: up = (stage_q[LastStage].last > 4'd5) ||
                     ((stage_q[LastStage].last == 4'd5) &&
                      (stage_q[LastStage].sticky || stage_q[LastStage].mag[0]));
      default:  up = 1'b0;
    endcase
    out_mag_d = stage_q[LastStage].mag + MagWidth'(up);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[LastStage];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_mag_q <= out_mag_d;
      out_neg_q <= stage_q[LastStage].neg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - OutBits)'(0), out_neg_q, out_mag_q};

  // Remainders carried between limbs are always decimal digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LastStage] |-> (stage_q[LastStage].rem < 4'd10 && stage_q[LastStage].last < 4'd10))
    else $error("digit out of range at divider end");

  // A beat with scale zero reaches the end with no discarded digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LastStage] && stage_q[LastStage].scale == '0) |->
      (stage_q[LastStage].last == 4'd0 && !stage_q[LastStage].sticky))
    else $error("digits discarded for zero scale");

  // Truncate never changes the quotient on the way out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[LastStage] && stage_q[LastStage].op == OP_TRUNC) |=>
      (out_mag_q == $past(stage_q[LastStage].mag)))
    else $error("truncate altered the magnitude");

  // A stalled output freezes the first divider stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (vld_q[0] == $past(vld_q[0])))
    else $error("pipeline moved during stall");

endmodule
